[design/ksc_pkg.sv]
// Package for the keyword substitution cipher: command codes, sequencer states,
// shared types and the wrap-around letter increment. Depends on nothing.
`default_nettype none

package ksc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int CHAR_W        = 8;
  localparam int RAW_LIMIT     = ALPHABET_SIZE + 1;

  typedef logic [LETTER_W-1:0] ksc_letter_t;
  typedef logic [CHAR_W-1:0]   ksc_char_t;

  localparam ksc_letter_t LAST_LETTER  = ksc_letter_t'(ALPHABET_SIZE - 1);
  localparam ksc_char_t   CHAR_UPPER_A = 8'h41;
  localparam ksc_char_t   CHAR_UPPER_Z = 8'h5A;
  localparam ksc_char_t   CHAR_LOWER_A = 8'h61;
  localparam ksc_char_t   CHAR_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_ENCODE = 2'd3
  } ksc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_FILL
  } ksc_state_t;

  // Key bookkeeping handed to the table builder.
  typedef struct packed {
    ksc_letter_t              count;
    ksc_letter_t              raw;
    ksc_letter_t              last;
    logic [ALPHABET_SIZE-1:0] used;
  } ksc_key_info_t;

  // One write into the cipher table.
  typedef struct packed {
    logic        we;
    ksc_letter_t addr;
    ksc_letter_t data;
  } ksc_wr_t;

  // Next letter position, wrapping from Z back to A.
  function automatic ksc_letter_t ksc_wrap_inc(ksc_letter_t v);
    ksc_letter_t r;
    r = (v == LAST_LETTER) ? '0 : v + ksc_letter_t'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ksc_in_if.sv]
// Input channel of the cipher: valid/ready handshake with command and byte.
// Stands alone; the command encoding lives in ksc_pkg.
`default_nettype none

interface ksc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_in;

  modport source (output valid, output cmd, output char_in, input ready);
  modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

`default_nettype wire

[design/ksc_out_if.sv]
// Output channel of the cipher: valid/ready handshake with the encoded byte.
// Stands alone.
`default_nettype none

interface ksc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

`default_nettype wire

[design/ksc_build_ctl.sv]
// Table builder: a small sequencer that lays the key letters and then the
// unused letters into the cipher table; a letter in the key gives no fill write. Uses ksc_pkg.
`default_nettype none

module ksc_build_ctl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  ksc_pkg::ksc_key_info_t info,
  input  ksc_pkg::ksc_letter_t  key_rd,
  output ksc_pkg::ksc_letter_t  key_idx,
  output ksc_pkg::ksc_wr_t      wr,
  output logic                  busy
);
  import ksc_pkg::*;

  ksc_state_t  state, state_next;
  ksc_letter_t idx;
  ksc_letter_t pos;
  ksc_letter_t c;
  ksc_letter_t step;
  ksc_letter_t c_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (info.count == '0) ? ST_FILL : ST_KEY;
        end
      end
      ST_KEY: begin
        if (idx == info.count - ksc_letter_t'(1)) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (step == LAST_LETTER) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    c_inc   = ksc_wrap_inc(c);
    key_idx = idx;
    busy    = (state != ST_IDLE);
    wr      = '0;
    case (state)
      ST_KEY: begin
        wr.we   = 1'b1;
        wr.addr = pos;
        wr.data = key_rd;
      end
      ST_FILL: begin
        wr.we   = ~info.used[c_inc];
        wr.addr = pos;
        wr.data = c_inc;
      end
      default: wr = '0;
    endcase
  end

  // With an empty key the fill starts at position 1 with letter B, which
  // yields the identity table.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          idx  <= '0;
          step <= '0;
          c    <= info.last;
          if (info.count == '0) begin
            pos <= ksc_letter_t'(1);
          end else if (info.raw > ksc_letter_t'(ALPHABET_SIZE)) begin
            pos <= '0;
          end else begin
            pos <= info.raw - ksc_letter_t'(1);
          end
        end
      end
      ST_KEY: begin
        idx <= idx + ksc_letter_t'(1);
        pos <= ksc_wrap_inc(pos);
      end
      ST_FILL: begin
        c    <= c_inc;
        step <= step + ksc_letter_t'(1);
        if (wr.we) begin
          pos <= ksc_wrap_inc(pos);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/keyword_substitution_cipher_top.sv]
// Top level of the keyword substitution cipher: key bookkeeping, cipher table,
// output register and assertions. Uses ksc_pkg, ksc_in_if, ksc_out_if and
// ksc_build_ctl.
//
// Usage. Every input transaction carries a command and a byte. Clear key
// drops the collected key, key byte adds one key byte, build table lays out
// a new 26-letter table from the key, and encode byte returns one output
// transaction with the encoded byte. Only encode produces an output.
// Clear, key byte and encode need no further work once accepted, so the
// next input transaction can be taken while no result is stalled. Encode
// results are registered into the output register on acceptance. After a
// build is accepted the table builder writes the kept key letters and then
// the unused letters into the table; in that time in_ch.ready is low. The
// builder writes the table through its single write port.
// Reset (synchronous, active high) sets the table to the identity mapping,
// clears the key and empties the output register; no clearing pass runs.
// When the receiver stalls with a result waiting, in_ch.ready drops until
// the result is taken, so no result is ever lost or overwritten; the
// result can be taken in the same cycle as a new transaction is accepted.
`default_nettype none

module keyword_substitution_cipher_top (
  input wire        clk,
  input wire        rst,
  ksc_in_if.sink    in_ch,
  ksc_out_if.source out_ch
);
  import ksc_pkg::*;

  // Key state.
  logic [ALPHABET_SIZE-1:0] letter_used;
  ksc_letter_t              key_letter_count;
  ksc_letter_t              raw_key_length;
  ksc_letter_t              last_key_letter;
  ksc_letter_t              key_letters [ALPHABET_SIZE];

  // Cipher table, one letter index per plain letter.
  ksc_letter_t              cipher_table [ALPHABET_SIZE];

  // Output register.
  logic                     out_valid;
  ksc_char_t                char_out;

  ksc_cmd_t                 cmd;
  logic                     in_fire;
  logic                     is_letter;
  ksc_letter_t              li;
  logic                     keep_letter;
  logic                     busy;
  ksc_key_info_t            info;
  ksc_letter_t              key_idx;
  ksc_letter_t              key_rd;
  ksc_wr_t                  wr;

  assign cmd     = ksc_cmd_t'(in_ch.cmd);
  assign in_fire = in_ch.valid && in_ch.ready;

  // Ready whenever no build is running and the output register is free or
  // being emptied in this cycle.
  assign in_ch.ready = !busy && (!out_valid || out_ch.ready);

  // Letter decode: folds lower case to upper case.
  always_comb begin
    is_letter = 1'b0;
    li        = '0;
    if (in_ch.char_in inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      is_letter = 1'b1;
      li        = ksc_letter_t'(in_ch.char_in - CHAR_UPPER_A);
    end else if (in_ch.char_in inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      is_letter = 1'b1;
      li        = ksc_letter_t'(in_ch.char_in - CHAR_LOWER_A);
    end
  end

  // A key letter is kept only on its first appearance.
  assign keep_letter = in_fire && (cmd == CMD_KEY) && is_letter && !letter_used[li] &&
                       (key_letter_count < ksc_letter_t'(ALPHABET_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used      <= '0;
      key_letter_count <= '0;
      raw_key_length   <= '0;
      last_key_letter  <= '0;
    end else if (in_fire) begin
      case (cmd)
        CMD_CLEAR: begin
          letter_used      <= '0;
          key_letter_count <= '0;
          raw_key_length   <= '0;
          last_key_letter  <= '0;
        end
        CMD_KEY: begin
          if (raw_key_length < ksc_letter_t'(RAW_LIMIT)) begin
            raw_key_length <= raw_key_length + ksc_letter_t'(1);
          end
          if (keep_letter) begin
            letter_used[li]  <= 1'b1;
            key_letter_count <= key_letter_count + ksc_letter_t'(1);
            last_key_letter  <= li;
          end
        end
        default: begin
          raw_key_length <= raw_key_length;
        end
      endcase
    end
  end

  // Kept key letters in order of arrival; only entries below the count are read.
  always_ff @(posedge clk) begin
    if (keep_letter) begin
      key_letters[key_letter_count] <= li;
    end
  end

  assign key_rd = key_letters[key_idx];

  assign info.count = key_letter_count;
  assign info.raw   = raw_key_length;
  assign info.last  = last_key_letter;
  assign info.used  = letter_used;

  ksc_build_ctl u_build (
    .clk     (clk),
    .rst     (rst),
    .start   (in_fire && (cmd == CMD_BUILD)),
    .info    (info),
    .key_rd  (key_rd),
    .key_idx (key_idx),
    .wr      (wr),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        cipher_table[i] <= ksc_letter_t'(i);
      end
    end else if (wr.we) begin
      cipher_table[wr.addr] <= wr.data;
    end
  end

  // Encode: letters map through the table, every other byte passes unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && (cmd == CMD_ENCODE)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (cmd == CMD_ENCODE)) begin
      if (is_letter) begin
        char_out <= CHAR_UPPER_A + ksc_char_t'(cipher_table[li]);
      end else begin
        char_out <= in_ch.char_in;
      end
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.char_out = char_out;

`ifndef SYNTH
  // No input transaction is taken while the table is being rebuilt.
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready)
    else $error("input accepted during table build");

  // A build command starts the table builder on the next cycle.
  a_build_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (cmd == CMD_BUILD)) |=> busy)
    else $error("build command did not start the builder");

  // The kept-letter count always matches the set of used letters.
  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(letter_used) == int'(key_letter_count))
    else $error("key letter count out of step with used letters");

  // A waiting result is never replaced by a new encode.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while a result is stalled");
`endif

endmodule

`default_nettype wire

[test/keyword_substitution_cipher_top_test.sv]
// Testbench for keyword_substitution_cipher_top: directed and random command streams
// checked against a scoreboard with its own cipher table. Depends on ksc_pkg,
// ksc_in_if, ksc_out_if and the block itself.
`timescale 1ns / 100ps

import ksc_pkg::*;

// Keeps its own copy of the key bookkeeping and the substitution table, works
// out the encoded byte for every accepted encode transaction and compares it
// with what the block returns.
class cipher_scoreboard;
  ksc_letter_t              subst_map [ALPHABET_SIZE];
  ksc_letter_t              key_order [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] key_used;
  int unsigned              key_count;
  int unsigned              raw_len;
  ksc_letter_t              key_last;
  ksc_char_t                expected_chars [$];
  int unsigned              mismatches;

  function new();
    for (int i = 0; i < ALPHABET_SIZE; i++) subst_map[i] = ksc_letter_t'(i);
    forget_key();
    mismatches = 0;
  endfunction

  function void forget_key();
    key_used  = '0;
    key_count = 0;
    raw_len   = 0;
    key_last  = '0;
  endfunction

  // Returns 1 with the letter index for A-Z or a-z, 0 for any other byte.
  function bit letter_of(ksc_char_t ch, output ksc_letter_t idx);
    idx = '0;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      idx = ksc_letter_t'(ch - CHAR_UPPER_A);
      return 1'b1;
    end
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      idx = ksc_letter_t'(ch - CHAR_LOWER_A);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Key letters go in from raw length minus one (or from zero once the raw
  // length has saturated), then the unused letters follow cyclically.
  function void rebuild_map();
    int unsigned pos;
    int unsigned c;
    if (key_count == 0) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) subst_map[i] = ksc_letter_t'(i);
      return;
    end
    pos = (raw_len > ALPHABET_SIZE) ? 0 : raw_len - 1;
    for (int i = 0; i < key_count; i++) begin
      if (pos >= ALPHABET_SIZE) pos = 0;
      subst_map[pos] = key_order[i];
      pos++;
    end
    c = key_last;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      c = (c + 1 >= ALPHABET_SIZE) ? 0 : c + 1;
      if (pos >= ALPHABET_SIZE) pos = 0;
      if (!key_used[c]) begin
        subst_map[pos] = ksc_letter_t'(c);
        pos++;
      end
    end
  endfunction

  function void note_input(ksc_cmd_t cmd, ksc_char_t ch);
    ksc_letter_t idx;
    bit          is_letter;
    is_letter = letter_of(ch, idx);
    case (cmd)
      CMD_CLEAR: forget_key();
      CMD_KEY: begin
        if (raw_len < RAW_LIMIT) raw_len++;
        if (is_letter && !key_used[idx] && key_count < ALPHABET_SIZE) begin
          key_order[key_count] = idx;
          key_count++;
          key_used[idx] = 1'b1;
          key_last = idx;
        end
      end
      CMD_BUILD: rebuild_map();
      default: begin
        if (is_letter) expected_chars.push_back(ksc_char_t'(CHAR_UPPER_A + subst_map[idx]));
        else expected_chars.push_back(ch);
      end
    endcase
  endfunction

  function void check_result(ksc_char_t actual);
    ksc_char_t want;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected char_out, expected none, actual %h", $time, actual);
      mismatches++;
      return;
    end
    want = expected_chars.pop_front();
    if (actual !== want) begin
      $display("%0t: char_out mismatch, expected %h, actual %h", $time, want, actual);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return expected_chars.size();
  endfunction
endclass

module keyword_substitution_cipher_top_test;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 90;
  // Distance between an upper-case letter and its lower-case form.
  localparam ksc_char_t   CASE_OFFSET  = CHAR_LOWER_A - CHAR_UPPER_A;

  logic clk;
  logic rst;

  ksc_in_if  in_ch ();
  ksc_out_if out_ch ();

  keyword_substitution_cipher_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cipher_scoreboard board = new();

  // When steady is set neither side inserts random gaps. The sender raises
  // hold_request to ask the receiver for one long hold-off.
  bit          steady;
  bit          hold_request;
  int unsigned items_sent;
  int unsigned cycle_count;

  // Free-running clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one transaction, with an occasional random gap in front of it, and
  // returns once the block has accepted it. Everything is sampled at the
  // rising edge before any nonblocking update lands, so the handshake seen
  // here is the one the block saw.
  task automatic send(input ksc_cmd_t cmd, input ksc_char_t ch);
    while (!steady && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.char_in <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_input(cmd, ch);
    items_sent++;
  endtask

  // Stops offering and waits until every encoded byte has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic ksc_char_t any_letter();
    ksc_char_t ch;
    ch = ksc_char_t'(CHAR_UPPER_A + $urandom_range(ALPHABET_SIZE - 1));
    if ($urandom_range(1)) ch = ch + CASE_OFFSET;
    return ch;
  endfunction

  // A byte that is not a letter, drawn from the whole 0..255 range.
  function automatic ksc_char_t any_non_letter();
    ksc_char_t ch;
    ch = ksc_char_t'($urandom_range(255));
    while ((ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
           (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z))
      ch = ksc_char_t'($urandom_range(255));
    return ch;
  endfunction

  function automatic ksc_char_t key_byte();
    return ($urandom_range(99) < 15) ? any_non_letter() : any_letter();
  endfunction

  function automatic ksc_char_t plain_byte();
    return ($urandom_range(99) < 70) ? any_letter() : ksc_char_t'($urandom_range(255));
  endfunction

  // Streams a key holding every letter exactly once in shuffled order, in
  // mixed case, so that the kept-letter count reaches its maximum.
  task automatic send_full_key();
    ksc_letter_t perm [ALPHABET_SIZE];
    ksc_letter_t tmp;
    int unsigned j;
    for (int i = 0; i < ALPHABET_SIZE; i++) perm[i] = ksc_letter_t'(i);
    for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < ALPHABET_SIZE; i++)
      send(CMD_KEY, ksc_char_t'(CHAR_UPPER_A + perm[i]) +
                    ($urandom_range(1) ? CASE_OFFSET : 8'h00));
  endtask

  // Receiver: checks every accepted output transaction and stalls at random.
  // A hold-off request from the sender turns into a long run of low ready
  // cycles, counted here.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) board.check_result(out_ch.char_out);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    int unsigned key_len;
    int unsigned burst;
    bit          drained_mid;

    steady        = 1'b0;
    hold_request  = 1'b0;
    items_sent    = 0;
    drained_mid   = 1'b0;
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_CLEAR;
    in_ch.char_in <= 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Right after reset the table is the identity mapping:
    // letters at both ends of both cases, bytes just outside the upper-case
    // range, and the extremes of the byte range.
    send(CMD_ENCODE, CHAR_UPPER_A);
    send(CMD_ENCODE, CHAR_UPPER_Z);
    send(CMD_ENCODE, CHAR_LOWER_A);
    send(CMD_ENCODE, CHAR_LOWER_Z);
    send(CMD_ENCODE, CHAR_UPPER_A - 8'd1);
    send(CMD_ENCODE, CHAR_UPPER_Z + 8'd1);
    send(CMD_ENCODE, 8'h00);
    send(CMD_ENCODE, 8'hFF);

    // A short key with a case-folded repeat and a non-letter, which both
    // still count toward the raw length.
    send(CMD_KEY, CHAR_LOWER_A + 8'd10);
    send(CMD_KEY, CHAR_UPPER_A + 8'd4);
    send(CMD_KEY, CHAR_LOWER_A + 8'd24);
    send(CMD_KEY, CHAR_UPPER_A + 8'd10);
    send(CMD_KEY, 8'h31);
    send(CMD_BUILD, 8'h00);
    send(CMD_ENCODE, CHAR_LOWER_A);
    send(CMD_ENCODE, CHAR_UPPER_A + 8'd16);

    // Clearing the key leaves the table alone; building from an empty key
    // restores the identity mapping.
    send(CMD_CLEAR, 8'hA5);
    send(CMD_ENCODE, CHAR_LOWER_A + 8'd1);
    send(CMD_BUILD, 8'h5A);
    send(CMD_ENCODE, CHAR_LOWER_A + 8'd12);

    // A build keeps the key, so later key bytes extend it.
    send(CMD_KEY, CHAR_LOWER_Z);
    send(CMD_BUILD, 8'h00);
    send(CMD_KEY, CHAR_UPPER_A + 8'd1);
    send(CMD_BUILD, 8'h00);
    send(CMD_ENCODE, CHAR_LOWER_A + 8'd24);

    // The sender waits for every result before the back-pressure test.
    drain();

    // The receiver holds off for a long stretch while the sender keeps
    // offering encode transactions back to back; the output register fills
    // and the block must drop in_ch.ready without losing anything.
    steady       = 1'b1;
    hold_request = 1'b1;
    repeat (24) send(CMD_ENCODE, plain_byte());
    steady = 1'b0;

    // Random part: mostly well-formed clear / key / build / encode sequences
    // with random content, the rest isolated transactions with random command
    // and byte. A window in the middle runs without any idling.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (items_sent >= 200 && items_sent < 300);
      if (!drained_mid && items_sent >= 330) begin
        drained_mid = 1'b1;
        drain();
      end
      if ($urandom_range(99) < 12) begin
        send(ksc_cmd_t'($urandom_range(3)), ksc_char_t'($urandom_range(255)));
      end else begin
        if ($urandom_range(99) < 80) send(CMD_CLEAR, ksc_char_t'($urandom_range(255)));
        case ($urandom_range(9))
          0: begin
            // Long key: the raw length saturates and placement starts at zero.
            key_len = $urandom_range(34, 27);
            repeat (key_len) send(CMD_KEY, key_byte());
          end
          1: begin
            send_full_key();
            repeat ($urandom_range(3)) send(CMD_KEY, key_byte());
          end
          default: begin
            key_len = $urandom_range(12);
            repeat (key_len) send(CMD_KEY, key_byte());
          end
        endcase
        send(CMD_BUILD, ksc_char_t'($urandom_range(255)));
        burst = $urandom_range(10, 2);
        repeat (burst) send(CMD_ENCODE, plain_byte());
      end
    end
    steady = 1'b0;

    // Wait for the last results and watch for anything stray before reporting.
    drain();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/ksc_pkg.sv
design/ksc_in_if.sv
design/ksc_out_if.sv
design/ksc_build_ctl.sv
design/keyword_substitution_cipher_top.sv
test/keyword_substitution_cipher_top_test.sv
